/* design/lpd_pkg.sv */
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the LED pattern duty generator.
// ----------------------------------------------------------------------------
package lpd_pkg;

	localparam int TICK_W   = 32;  // default tick width
	localparam int LEVEL_W  = 16;  // default level width (Q0.L fractions)
	localparam int PERIOD_W = 16;  // period and offset register width
	localparam int REG_W    = 16;  // written bits kept by the wide registers
	localparam int ADDR_W   = 5;   // byte address of five 32-bit registers
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_ON      = 2'd1,
		MODE_BREATHE = 2'd2,
		MODE_TWINKLE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_PERIOD = 3'd1,
		REG_BLINK  = 3'd2,
		REG_BRIGHT = 3'd3,
		REG_OFFSET = 3'd4
	} reg_idx_t;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1000);
	localparam int                  BLINK_RST  = 32768;
	localparam int                  BRIGHT_RST = 65535;

endpackage

/* design/lpd_if.sv */
// ----------------------------------------------------------------------------
// lpd_if
// Valid/ready channels of the duty generator: tick words in, duty words out.
// ----------------------------------------------------------------------------
interface lpd_tick_if #(
	parameter int TICK_WIDTH = lpd_pkg::TICK_W
);
	logic                  valid;
	logic                  ready;
	logic [TICK_WIDTH-1:0] tick_time;

	modport source (output valid, output tick_time, input ready);
	modport sink   (input valid, input tick_time, output ready);
endinterface

interface lpd_duty_if #(
	parameter int LEVEL_WIDTH = lpd_pkg::LEVEL_W
);
	logic                   valid;
	logic                   ready;
	logic [LEVEL_WIDTH-1:0] pwm_duty;

	modport source (output valid, output pwm_duty, input ready);
	modport sink   (input valid, input pwm_duty, output ready);
endinterface

/* design/led_pattern_duty_generator.sv */
// ----------------------------------------------------------------------------
// led_pattern_duty_generator
// Millisecond tick in, gamma-2 PWM duty (Q0.L) out for one LED pattern.
// ----------------------------------------------------------------------------
// Usage:
//   tick (sink):   one tick_time word per valid/ready transfer.
//   duty (source): one pwm_duty word per accepted tick, in order.
//   APB port:      mode, period, blink fraction, brightness, phase offset at
//                  byte addresses 0, 4, 8, 12, 16. Write only while idle.
// Throughput: one word per cycle, sustained while duty.ready stays high.
// Path: an accepted tick reaches pwm_duty through the two cell rows: the
//   modulo row (one cell per tick bit) and the level division row (one cell
//   per bit of 2*pos*brightness, LEVEL_WIDTH + 16 bits), plus five registers
//   around them.
// Stall: an output register and a skid register follow the pipeline. While a
//   result waits, the pipeline keeps moving until a word lands in the skid
//   register; then tick.ready drops and the whole pipeline holds.
// Reset: asynchronous, active low. Pipeline and output empty, registers at
//   their reset values (off, period 1000, fraction 1/2, full brightness).
// ----------------------------------------------------------------------------
module led_pattern_duty_generator #(
	parameter int TICK_WIDTH  = lpd_pkg::TICK_W,
	parameter int LEVEL_WIDTH = lpd_pkg::LEVEL_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lpd_tick_if.sink                   tick,
	lpd_duty_if.source                 duty,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lpd_pkg::ADDR_W-1:0] paddr,
	input  logic [lpd_pkg::DATA_W-1:0] pwdata,
	output logic [lpd_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int PW = lpd_pkg::PERIOD_W;
	localparam int TW = TICK_WIDTH;
	localparam int LW = LEVEL_WIDTH;
	localparam int NW = PW + LW;  // width of 2*pos*brightness

	lpd_pkg::mode_t mode;
	logic [PW-1:0]  period;
	logic [PW-1:0]  offset;
	logic [LW-1:0]  bright;
	logic [LW-1:0]  bright_sq;
	logic [PW-1:0]  threshold;

	lpd_apb_regs #(
		.LEVEL_WIDTH(LW)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.mode      (mode),
		.period    (period),
		.offset    (offset),
		.bright    (bright),
		.bright_sq (bright_sq),
		.threshold (threshold)
	);

	logic en;
	logic skid_v_q;
	logic out_v_q;
	logic [LW-1:0] out_q;
	logic [LW-1:0] skid_q;

	// pipeline moves whenever the skid register is free
	assign en         = !skid_v_q;
	assign tick.ready = en;

	// stage 1: tick plus offset, wrapping
	logic          v_s1;
	logic [TW-1:0] sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= tick.tick_time + TW'(offset);
		end
	end

	// modulo row: position in the cycle
	logic          m_v;
	logic [PW-1:0] m_pos;
	logic [TW-1:0] m_quot;

	lpd_div_chain #(
		.DW(TW),
		.PW(PW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.divisor  (period),
		.v_in     (v_s1),
		.dividend (sum_s1),
		.v_out    (m_v),
		.rem      (m_pos),
		.quot     (m_quot)
	);

	// stage 2: triangle fold and twinkle compare
	logic          v_s2;
	logic [PW-1:0] fold_s2;
	logic          flag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= m_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_s2 <= (m_pos > (period >> 1)) ? period - m_pos : m_pos;
			flag_s2 <= m_pos < threshold;
		end
	end

	// stage 3: 2*pos*brightness; folded pos is at most period/2, so 2*pos fits
	logic          v_s3;
	logic [NW-1:0] prod_s3;
	logic          flag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= NW'({fold_s2[PW-2:0], 1'b0}) * NW'(bright);
			flag_s3 <= flag_s2;
		end
	end

	// level division row, twinkle flag travels alongside
	logic          d_v;
	logic [PW-1:0] d_rem;
	logic [NW-1:0] d_quot;
	logic          flag_q [NW];

	lpd_div_chain #(
		.DW(NW),
		.PW(PW)
	) u_lvl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.divisor  (period),
		.v_in     (v_s3),
		.dividend (prod_s3),
		.v_out    (d_v),
		.rem      (d_rem),
		.quot     (d_quot)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			flag_q[0] <= flag_s3;
			for (int i = 1; i < NW; i++) begin
				flag_q[i] <= flag_q[i-1];
			end
		end
	end

	// stage 4: gamma square of the breathing level
	logic             v_s4;
	logic [LW-1:0]    sq_s4;
	logic             flag_s4;
	logic [2*LW-1:0]  lvl_prod;

	assign lvl_prod = (2*LW)'(d_quot[LW-1:0]) * (2*LW)'(d_quot[LW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= d_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4   <= lvl_prod[2*LW-1:LW];
			flag_s4 <= flag_q[NW-1];
		end
	end

	// mode select
	logic [LW-1:0] duty_sel;

	always_comb begin
		case (mode)
			lpd_pkg::MODE_OFF:     duty_sel = '0;
			lpd_pkg::MODE_ON:      duty_sel = bright_sq;
			lpd_pkg::MODE_BREATHE: duty_sel = sq_s4;
			lpd_pkg::MODE_TWINKLE: duty_sel = flag_s4 ? bright_sq : '0;
			default:               duty_sel = '0;
		endcase
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (duty.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s4) begin
			if (!out_v_q || duty.ready) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (duty.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (duty.ready) begin
				out_q <= skid_q;
			end
		end else if (v_s4) begin
			if (!out_v_q || duty.ready) begin
				out_q <= duty_sel;
			end else begin
				skid_q <= duty_sel;
			end
		end
	end

	assign duty.valid    = out_v_q;
	assign duty.pwm_duty = out_q;

	// modulo quotient, level remainder and quotient bits above the level are not needed
	logic unused_bits;
	assign unused_bits = ^{m_quot, d_rem, d_quot[NW-1:LW]};

	// a word sits in the skid register only behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word without output word");

	// the skid register fills only when the output word was held
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !duty.ready))
		else $error("skid filled while output free");

	// the skid register drains only when the output word was taken
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(skid_v_q) |-> $past(duty.ready))
		else $error("skid drained without output transfer");

	// a held output word is not overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !duty.ready) |=> (out_v_q && $stable(out_q)))
		else $error("held output word changed");

endmodule

/* design/lpd_div_cell.sv */
// ----------------------------------------------------------------------------
// lpd_div_cell
// One restoring-division step: shifts the top dividend bit into the partial
// remainder, subtracts the divisor when it fits, shifts the quotient bit in.
// ----------------------------------------------------------------------------
module lpd_div_cell #(
	parameter int DW = 32,
	parameter int PW = lpd_pkg::PERIOD_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [PW-1:0] divisor,
	input  logic          v_in,
	input  logic [PW-1:0] rem_in,
	input  logic [DW-1:0] wq_in,
	output logic          v_out,
	output logic [PW-1:0] rem_out,
	output logic [DW-1:0] wq_out
);

	logic [PW:0]   trial;
	logic          fits;
	logic [PW:0]   diff;
	logic [PW-1:0] rem_nxt;

	assign trial   = {rem_in, wq_in[DW-1]};
	assign fits    = trial >= {1'b0, divisor};
	assign diff    = trial - {1'b0, divisor};
	assign rem_nxt = fits ? diff[PW-1:0] : trial[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	// word register: dividend bits leave at the top, quotient bits enter below
	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= rem_nxt;
			wq_out  <= {wq_in[DW-2:0], fits};
		end
	end

endmodule

/* design/lpd_div_chain.sv */
// ----------------------------------------------------------------------------
// lpd_div_chain
// Row of DW division cells; one dividend bit per cell, one word per cycle while en is high.
// Gives the remainder and the quotient once the word has passed all DW cells.
// ----------------------------------------------------------------------------
module lpd_div_chain #(
	parameter int DW = 32,
	parameter int PW = lpd_pkg::PERIOD_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [PW-1:0] divisor,
	input  logic          v_in,
	input  logic [DW-1:0] dividend,
	output logic          v_out,
	output logic [PW-1:0] rem,
	output logic [DW-1:0] quot
);

	logic          v_c   [DW+1];
	logic [PW-1:0] rem_c [DW+1];
	logic [DW-1:0] wq_c  [DW+1];

	assign v_c[0]   = v_in;
	assign rem_c[0] = '0;
	assign wq_c[0]  = dividend;

	for (genvar i = 0; i < DW; i++) begin : g_cell
		lpd_div_cell #(
			.DW(DW),
			.PW(PW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.divisor (divisor),
			.v_in    (v_c[i]),
			.rem_in  (rem_c[i]),
			.wq_in   (wq_c[i]),
			.v_out   (v_c[i+1]),
			.rem_out (rem_c[i+1]),
			.wq_out  (wq_c[i+1])
		);
	end

	assign v_out = v_c[DW];
	assign rem   = rem_c[DW];
	assign quot  = wq_c[DW];

endmodule

/* design/lpd_apb_regs.sv */
// ----------------------------------------------------------------------------
// lpd_apb_regs
// APB register file of the duty generator, plus the values derived from it
// (saturated period, twinkle threshold, squared brightness).
// ----------------------------------------------------------------------------
module lpd_apb_regs #(
	parameter int LEVEL_WIDTH = lpd_pkg::LEVEL_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lpd_pkg::ADDR_W-1:0]    paddr,
	input  logic [lpd_pkg::DATA_W-1:0]    pwdata,
	output logic [lpd_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output lpd_pkg::mode_t                mode,
	output logic [lpd_pkg::PERIOD_W-1:0]  period,
	output logic [lpd_pkg::PERIOD_W-1:0]  offset,
	output logic [LEVEL_WIDTH-1:0]        bright,
	output logic [LEVEL_WIDTH-1:0]        bright_sq,
	output logic [lpd_pkg::PERIOD_W-1:0]  threshold
);

	localparam int PW = lpd_pkg::PERIOD_W;
	localparam int DW = lpd_pkg::DATA_W;

	lpd_pkg::mode_t   mode_q;
	logic [PW-1:0]    period_q;
	logic [LEVEL_WIDTH-1:0] blink_q;
	logic [LEVEL_WIDTH-1:0] bright_q;
	logic [PW-1:0]    offset_q;
	logic [LEVEL_WIDTH-1:0] bright_sq_q;
	logic [PW-1:0]    threshold_q;
	logic [PW-1:0]    period_eff;
	logic [LEVEL_WIDTH+PW-1:0]    thr_prod;
	logic [2*LEVEL_WIDTH-1:0]     sq_prod;
	logic             wr;
	logic [2:0]       idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= lpd_pkg::MODE_OFF;
			period_q <= lpd_pkg::PERIOD_RST;
			blink_q  <= LEVEL_WIDTH'(lpd_pkg::BLINK_RST);
			bright_q <= LEVEL_WIDTH'(lpd_pkg::BRIGHT_RST);
			offset_q <= '0;
		end else if (wr) begin
			case (idx)
				lpd_pkg::REG_MODE:   mode_q   <= lpd_pkg::mode_t'(pwdata[1:0]);
				lpd_pkg::REG_PERIOD: period_q <= pwdata[PW-1:0];
				lpd_pkg::REG_BLINK:  blink_q  <= LEVEL_WIDTH'(pwdata[lpd_pkg::REG_W-1:0]);
				lpd_pkg::REG_BRIGHT: bright_q <= LEVEL_WIDTH'(pwdata[lpd_pkg::REG_W-1:0]);
				lpd_pkg::REG_OFFSET: offset_q <= pwdata[PW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			lpd_pkg::REG_MODE:   prdata = DW'(mode_q);
			lpd_pkg::REG_PERIOD: prdata = DW'(period_q);
			lpd_pkg::REG_BLINK:  prdata = DW'(blink_q);
			lpd_pkg::REG_BRIGHT: prdata = DW'(bright_q);
			lpd_pkg::REG_OFFSET: prdata = DW'(offset_q);
			default:             prdata = '0;
		endcase
	end

	// zero period behaves as one
	assign period_eff = (period_q == '0) ? PW'(1) : period_q;

	assign thr_prod = (LEVEL_WIDTH+PW)'(blink_q) * (LEVEL_WIDTH+PW)'(period_eff);
	assign sq_prod  = (2*LEVEL_WIDTH)'(bright_q) * (2*LEVEL_WIDTH)'(bright_q);

	always_ff @(posedge clk) begin
		threshold_q <= thr_prod[LEVEL_WIDTH+PW-1:LEVEL_WIDTH];
		bright_sq_q <= sq_prod[2*LEVEL_WIDTH-1:LEVEL_WIDTH];
	end

	assign mode      = mode_q;
	assign period    = period_eff;
	assign offset    = offset_q;
	assign bright    = bright_q;
	assign bright_sq = bright_sq_q;
	assign threshold = threshold_q;

endmodule
